/* sv/cbsb_pkg.sv */
package cbsb_pkg;

  localparam int FRAC_BITS = 16;

  // Port widths, fixed by the item fields.
  localparam int POS_W   = FRAC_BITS + 3;
  localparam int KIND_W  = 3;
  localparam int VAL_W   = FRAC_BITS + 1;
  localparam int SLOPE_W = FRAC_BITS + 3;

  // Datapath widths. Bounds assume |position| <= 2 inside a segment; outside
  // the support every coefficient is zero, so the products stay zero.
  localparam int COEF_W = 5;
  localparam int A_W    = FRAC_BITS + 5;
  localparam int B_W    = FRAC_BITS + 6;
  localparam int H_W    = 2 * FRAC_BITS + 7;
  localparam int G_W    = 2 * FRAC_BITS + 8;
  localparam int HQ_W   = FRAC_BITS + 7;
  localparam int V_W    = 2 * FRAC_BITS + 8;
  localparam int XV_W   = FRAC_BITS + 2;
  localparam int XS_W   = FRAC_BITS + 3;
  localparam int MAG_W  = FRAC_BITS + 2;

  // Division by three through a reciprocal; exact for x below 2^(K-1).
  localparam int KV = FRAC_BITS + 3;
  localparam int KS = FRAC_BITS + 4;
  localparam logic [KV-1:0] RECIP_V = KV'(((64'd1 << KV) + 64'd2) / 64'd3);
  localparam logic [KS-1:0] RECIP_S = KS'(((64'd1 << KS) + 64'd2) / 64'd3);

  // Saturation points expressed before the division by three.
  localparam logic [XV_W-1:0] XV_CAP = XV_W'(3) << FRAC_BITS;
  localparam logic [XS_W-1:0] XS_CAP = XS_W'(3) << (FRAC_BITS + 1);

  localparam logic [VAL_W-1:0]          VAL_ONE   = VAL_W'(1) << FRAC_BITS;
  localparam logic signed [SLOPE_W-1:0] SLOPE_LIM = SLOPE_W'(2) << FRAC_BITS;

  localparam int NUM_STAGES = 7;

  localparam logic [KIND_W-1:0] KIND_INTERIOR = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ADJ_LO   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BOUNDARY = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ADJ_HI   = 3'd4;

  typedef enum logic [3:0] {
    CUB_NONE    = 4'd0,
    CUB_OUTER_L = 4'd1,
    CUB_INNER_L = 4'd2,
    CUB_INNER_R = 4'd3,
    CUB_OUTER_R = 4'd4,
    CUB_EDGE_L  = 4'd5,
    CUB_EDGE_R  = 4'd6,
    CUB_NEAR_L  = 4'd7,
    CUB_NEAR_R  = 4'd8
  } cubic_id_t;

  // Cubic times six: (c3 x^3 + c2 x^2 + c1 x + c0) / 6.
  typedef struct packed {
    logic signed [COEF_W-1:0] c3;
    logic signed [COEF_W-1:0] c2;
    logic signed [COEF_W-1:0] c1;
    logic signed [COEF_W-1:0] c0;
  } cubic_t;

  function automatic logic signed [POS_W-1:0] knot(input int k);
    return POS_W'(k) <<< FRAC_BITS;
  endfunction

  function automatic cubic_t mk_cubic(input int a, input int b, input int c, input int d);
    cubic_t r;
    r.c3 = COEF_W'(a);
    r.c2 = COEF_W'(b);
    r.c1 = COEF_W'(c);
    r.c0 = COEF_W'(d);
    return r;
  endfunction

  function automatic cubic_t cubic_coef(input cubic_id_t id);
    cubic_t r;
    case (id)
      CUB_OUTER_L: r = mk_cubic( 1,  6,  12, 8);
      CUB_INNER_L: r = mk_cubic(-1,  0,   6, 6);
      CUB_INNER_R: r = mk_cubic( 1,  0,  -6, 6);
      CUB_OUTER_R: r = mk_cubic(-1,  6, -12, 8);
      CUB_EDGE_L:  r = mk_cubic(-2, -6,   0, 4);
      CUB_EDGE_R:  r = mk_cubic( 3, -6,   0, 4);
      CUB_NEAR_L:  r = mk_cubic(-3, -6,   0, 4);
      CUB_NEAR_R:  r = mk_cubic( 2, -6,   0, 4);
      default:     r = mk_cubic( 0,  0,   0, 0);
    endcase
    return r;
  endfunction

  // Segment 0 is [-2,-1], segment 3 is [1,2].
  function automatic cubic_id_t seg_cubic(input logic [KIND_W-1:0] kind,
                                          input logic [1:0] seg);
    cubic_id_t r;
    r = CUB_NONE;
    case (kind)
      KIND_INTERIOR: begin
        case (seg)
          2'd0:    r = CUB_OUTER_L;
          2'd1:    r = CUB_INNER_L;
          2'd2:    r = CUB_INNER_R;
          default: r = CUB_OUTER_R;
        endcase
      end
      KIND_ADJ_LO: begin
        case (seg)
          2'd0:    r = CUB_NONE;
          2'd1:    r = CUB_EDGE_L;
          2'd2:    r = CUB_EDGE_R;
          default: r = CUB_OUTER_R;
        endcase
      end
      KIND_BOUNDARY: begin
        case (seg)
          2'd0:    r = CUB_OUTER_L;
          2'd1:    r = CUB_NEAR_L;
          2'd2:    r = CUB_EDGE_R;
          default: r = CUB_OUTER_R;
        endcase
      end
      KIND_ADJ_HI: begin
        case (seg)
          2'd0:    r = CUB_OUTER_L;
          2'd1:    r = CUB_NEAR_L;
          2'd2:    r = CUB_NEAR_R;
          default: r = CUB_NONE;
        endcase
      end
      default: r = CUB_NONE;
    endcase
    return r;
  endfunction

endpackage

/* sv/cbsb_seg_decode.sv */
module cbsb_seg_decode import cbsb_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [POS_W-1:0] position,
  input  logic [KIND_W-1:0]       basis_kind,
  output logic signed [POS_W-1:0] pos_q,
  output cubic_t                  coef_q
);

  cubic_id_t id;

  // Scanning from the top down lets the lowest matching segment win at a knot.
  always_comb begin
    id = CUB_NONE;
    for (int k = 3; k >= 0; k--) begin
      if (seg_cubic(basis_kind, 2'(k)) != CUB_NONE &&
          position >= knot(k - 2) && position <= knot(k - 1)) begin
        id = seg_cubic(basis_kind, 2'(k));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_q  <= position;
      coef_q <= cubic_coef(id);
    end
  end

endmodule

/* sv/cbsb_poly.sv */
module cbsb_poly import cbsb_pkg::*; (
  input  logic                     clk,
  input  logic [1:0]               en,
  input  logic signed [POS_W-1:0]  pos,
  input  cubic_t                   coef,
  output logic signed [POS_W-1:0]  pos_q,
  output logic signed [COEF_W-1:0] c0_q,
  output logic signed [H_W-1:0]    h_q,
  output logic signed [G_W-1:0]    g_q
);

  logic signed [POS_W+COEF_W-1:0] c3p;
  logic signed [A_W-1:0]          a_next;
  logic signed [B_W-1:0]          b_next;
  logic signed [A_W-1:0]          a;
  logic signed [B_W-1:0]          b;
  logic signed [POS_W-1:0]        pos2;
  logic signed [COEF_W-1:0]       c1_2;
  logic signed [COEF_W-1:0]       c0_2;
  logic signed [A_W+POS_W-1:0]    ap;
  logic signed [B_W+POS_W-1:0]    bp;

  assign c3p    = $signed(coef.c3) * pos;
  assign a_next = A_W'(c3p) + (A_W'($signed(coef.c2)) <<< FRAC_BITS);
  assign b_next = (B_W'(c3p) <<< 1) + B_W'(c3p) +
                  (B_W'($signed(coef.c2)) <<< (FRAC_BITS + 1));

  assign ap = a * pos2;
  assign bp = b * pos2;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a    <= a_next;
      b    <= b_next;
      pos2 <= pos;
      c1_2 <= $signed(coef.c1);
      c0_2 <= $signed(coef.c0);
    end
    if (en[1]) begin
      h_q   <= H_W'(ap) + (H_W'(c1_2) <<< (2 * FRAC_BITS));
      g_q   <= G_W'(bp) + (G_W'(c1_2) <<< (2 * FRAC_BITS));
      pos_q <= pos2;
      c0_q  <= c0_2;
    end
  end

endmodule

/* sv/cbsb_value.sv */
module cbsb_value import cbsb_pkg::*; (
  input  logic                     clk,
  input  logic [3:0]               en,
  input  logic signed [H_W-1:0]    h,
  input  logic signed [POS_W-1:0]  pos,
  input  logic signed [COEF_W-1:0] c0,
  output logic [VAL_W-1:0]         shape_value_q
);

  logic [H_W-1:0]               h_mag;
  logic [H_W:0]                 h_sum;
  logic [H_W-FRAC_BITS:0]       hr_mag;
  logic signed [HQ_W-1:0]       hq_next;
  logic signed [HQ_W-1:0]       hq;
  logic signed [POS_W-1:0]      pos4;
  logic signed [COEF_W-1:0]     c0_4;
  logic signed [HQ_W+POS_W-1:0] vp;
  logic signed [V_W-1:0]        v;
  logic [V_W-1:0]               v_sum;
  logic [V_W-FRAC_BITS-2:0]     xv_full;
  logic [XV_W-1:0]              xv_next;
  logic [XV_W-1:0]              xv;
  logic [XV_W+KV-1:0]           vprod;

  // Round away FRAC_BITS fraction bits, to units of 2^-FRAC_BITS, ties away from zero.
  assign h_mag   = h[H_W-1] ? H_W'(-h) : H_W'(h);
  assign h_sum   = {1'b0, h_mag} + ((H_W + 1)'(1) << (FRAC_BITS - 1));
  assign hr_mag  = h_sum[H_W:FRAC_BITS];
  assign hq_next = h[H_W-1] ? -$signed(HQ_W'(hr_mag)) : $signed(HQ_W'(hr_mag));

  assign vp = hq * pos4;

  // A negative value saturates to zero, so only the positive branch is divided.
  assign v_sum   = V_W'(v) + (V_W'(3) << FRAC_BITS);
  assign xv_full = v_sum[V_W-1:FRAC_BITS+1];
  always_comb begin
    if (v[V_W-1]) begin
      xv_next = '0;
    end else if (xv_full >= (V_W - FRAC_BITS - 1)'(XV_CAP)) begin
      xv_next = XV_CAP;
    end else begin
      xv_next = XV_W'(xv_full);
    end
  end

  assign vprod = xv * RECIP_V;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      hq   <= hq_next;
      pos4 <= pos;
      c0_4 <= c0;
    end
    if (en[1]) begin
      v <= V_W'(vp) + (V_W'(c0_4) <<< (2 * FRAC_BITS));
    end
    if (en[2]) begin
      xv <= xv_next;
    end
    if (en[3]) begin
      shape_value_q <= vprod[KV+VAL_W-1:KV];
    end
  end

endmodule

/* sv/cbsb_slope.sv */
module cbsb_slope import cbsb_pkg::*; (
  input  logic                      clk,
  input  logic [3:0]                en,
  input  logic signed [G_W-1:0]     g,
  output logic signed [SLOPE_W-1:0] shape_slope_q
);

  logic [G_W-1:0]            g_mag;
  logic                      neg4;
  logic [G_W:0]              g_sum;
  logic [G_W-FRAC_BITS-1:0]  xs_full;
  logic [XS_W-1:0]           xs_next;
  logic [XS_W-1:0]           xs;
  logic                      neg5;
  logic [XS_W+KS-1:0]        sprod;
  logic [MAG_W-1:0]          qs;
  logic                      neg6;

  // The magnitude is rounded and saturated, then the sign is put back, which
  // gives rounding ties away from zero.
  assign g_sum   = {1'b0, g_mag} + ((G_W + 1)'(3) << FRAC_BITS);
  assign xs_full = g_sum[G_W:FRAC_BITS+1];
  assign xs_next = (xs_full >= (G_W - FRAC_BITS)'(XS_CAP)) ? XS_CAP : XS_W'(xs_full);
  assign sprod   = xs * RECIP_S;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      g_mag <= g[G_W-1] ? G_W'(-g) : G_W'(g);
      neg4  <= g[G_W-1];
    end
    if (en[1]) begin
      xs   <= xs_next;
      neg5 <= neg4;
    end
    if (en[2]) begin
      qs   <= sprod[KS+MAG_W-1:KS];
      neg6 <= neg5;
    end
    if (en[3]) begin
      shape_slope_q <= neg6 ? -$signed(SLOPE_W'(qs)) : $signed(SLOPE_W'(qs));
    end
  end

endmodule

/* sv/cubic_bspline_basis_eval_unit.sv */
// Throughput: one item per cycle; the seven-stage pipeline stalls only when it
// is full and result_ready is low. Reset (synchronous, active high) clears
// every stage valid bit; data registers are not reset. The block holds no
// other state.
module cubic_bspline_basis_eval_unit import cbsb_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      valid,
  output logic                      ready,
  input  logic signed [POS_W-1:0]   position,
  input  logic [KIND_W-1:0]         basis_kind,
  output logic                      result_valid,
  input  logic                      result_ready,
  output logic [VAL_W-1:0]          shape_value,
  output logic signed [SLOPE_W-1:0] shape_slope
);

  // Stage map:
  //   1  segment decode and coefficient lookup
  //   2  inner Horner term for the value and the slope
  //   3  second Horner term (one multiplier each)
  //   4  value: round to units of 2^-FRAC_BITS; slope: split sign and magnitude
  //   5  value: last Horner multiply; slope: round, scale and saturate
  //   6  value: round, scale and saturate; slope: divide by three
  //   7  value: divide by three; slope: restore the sign
  // Each stage moves forward when it is empty or the stage after it moves, so
  // bubbles are squeezed out and a stall at the output loses no item.

  logic [NUM_STAGES-1:0]    stage_valid;
  logic [NUM_STAGES-1:0]    stage_en;

  logic signed [POS_W-1:0]  pos1;
  cubic_t                   coef1;
  logic signed [POS_W-1:0]  pos3;
  logic signed [COEF_W-1:0] c0_3;
  logic signed [H_W-1:0]    h3;
  logic signed [G_W-1:0]    g3;

  always_comb begin
    stage_en[NUM_STAGES-1] = !stage_valid[NUM_STAGES-1] || result_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      stage_en[i] = !stage_valid[i] || stage_en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (stage_en[0]) begin
        stage_valid[0] <= valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (stage_en[i]) begin
          stage_valid[i] <= stage_valid[i-1];
        end
      end
    end
  end

  assign ready        = stage_en[0];
  assign result_valid = stage_valid[NUM_STAGES-1];

  cbsb_seg_decode u_seg (
    .clk        (clk),
    .en         (stage_en[0]),
    .position   (position),
    .basis_kind (basis_kind),
    .pos_q      (pos1),
    .coef_q     (coef1)
  );

  cbsb_poly u_poly (
    .clk   (clk),
    .en    (stage_en[2:1]),
    .pos   (pos1),
    .coef  (coef1),
    .pos_q (pos3),
    .c0_q  (c0_3),
    .h_q   (h3),
    .g_q   (g3)
  );

  cbsb_value u_value (
    .clk           (clk),
    .en            (stage_en[6:3]),
    .h             (h3),
    .pos           (pos3),
    .c0            (c0_3),
    .shape_value_q (shape_value)
  );

  cbsb_slope u_slope (
    .clk           (clk),
    .en            (stage_en[6:3]),
    .g             (g3),
    .shape_slope_q (shape_slope)
  );

  // A delivered value never exceeds one.
  a_value_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> shape_value <= VAL_ONE)
    else $error("shape_value above one");

  // A delivered slope stays within plus and minus two.
  a_slope_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (shape_slope <= SLOPE_LIM && shape_slope >= -SLOPE_LIM))
    else $error("shape_slope out of range");

  // The input is held off only when every stage holds an item.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !ready |-> &stage_valid)
    else $error("input stalled with a bubble in the pipeline");

  // An accepted item occupies the first stage on the next cycle.
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    valid && ready |=> stage_valid[0])
    else $error("accepted item did not enter the pipeline");

endmodule

/* bench/tb_cubic_bspline_basis_eval_unit.sv */
`timescale 1ns / 1ps

// Self-checking bench for the cubic B-spline shape function unit. A bit-exact
// predictor computes the expected value and slope for every item the unit
// accepts. A monitor compares each result the unit hands over with the oldest
// expectation. The stimulus starts with the knots of every basis kind and the
// field extremes. Random traffic follows under several idling patterns, and
// last comes a long output stall that fills the pipeline.
module tb_cubic_bspline_basis_eval_unit;
  import cbsb_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int WATCHDOG_LIMIT = 2000;

  // Expected output of one item, at the port widths of the unit.
  typedef struct {
    logic [VAL_W-1:0]          value;
    logic signed [SLOPE_W-1:0] slope;
  } shape_result_t;

  logic                      clk;
  logic                      rst;
  logic                      valid;
  logic                      ready;
  logic signed [POS_W-1:0]   position;
  logic [KIND_W-1:0]         basis_kind;
  logic                      result_valid;
  logic                      result_ready;
  logic [VAL_W-1:0]          shape_value;
  logic signed [SLOPE_W-1:0] shape_slope;

  shape_result_t shape_expect[$];
  shape_result_t oldest_shape;
  int            fail_count;
  int            idle_cycles;

  // Knobs shared by the sender task and the receiver process. Both are
  // percentages of cycles. The hold flag parks the receiver while it is set.
  int   send_idle_pct;
  int   rx_stall_pct;
  logic rx_hold;

  cubic_bspline_basis_eval_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .valid        (valid),
    .ready        (ready),
    .position     (position),
    .basis_kind   (basis_kind),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .shape_value  (shape_value),
    .shape_slope  (shape_slope)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Division with rounding to nearest. Ties round away from zero.
  function automatic longint round_div(input longint num, input longint den);
    if (num >= 0) begin
      return (num + den / 2) / den;
    end
    return -((-num + den / 2) / den);
  endfunction

  // Bit-exact value and slope for one position and basis kind. Each kind maps
  // the four unit segments of [-2,2] to a cubic, scaled by six, or to no cubic
  // at all. The first segment that holds a cubic and contains the position is
  // used, so the lower segment wins on a shared knot.
  function automatic shape_result_t eval_shape(input logic signed [POS_W-1:0] pos,
                                               input logic [KIND_W-1:0] kind);
    shape_result_t res;
    cubic_id_t     segs [4];
    cubic_id_t     pick;
    longint        coef [4];
    longint        s;
    longint        p;
    longint        h;
    longint        v;
    longint        g;
    longint        val;
    longint        slope;
    s    = longint'(1) << FRAC_BITS;
    p    = longint'(pos);
    pick = CUB_NONE;
    case (kind)
      KIND_INTERIOR: segs = '{CUB_OUTER_L, CUB_INNER_L, CUB_INNER_R, CUB_OUTER_R};
      KIND_ADJ_LO:   segs = '{CUB_NONE, CUB_EDGE_L, CUB_EDGE_R, CUB_OUTER_R};
      KIND_BOUNDARY: segs = '{CUB_OUTER_L, CUB_NEAR_L, CUB_EDGE_R, CUB_OUTER_R};
      KIND_ADJ_HI:   segs = '{CUB_OUTER_L, CUB_NEAR_L, CUB_NEAR_R, CUB_NONE};
      default:       segs = '{CUB_NONE, CUB_NONE, CUB_NONE, CUB_NONE};
    endcase
    for (int k = 0; k < 4; k++) begin
      if (pick == CUB_NONE && segs[k] != CUB_NONE &&
          p >= (k - 2) * s && p <= (k - 1) * s) begin
        pick = segs[k];
      end
    end
    // Coefficients in the order x^3, x^2, x, 1.
    case (pick)
      CUB_OUTER_L: coef = '{ 1,  6,  12, 8};
      CUB_INNER_L: coef = '{-1,  0,   6, 6};
      CUB_INNER_R: coef = '{ 1,  0,  -6, 6};
      CUB_OUTER_R: coef = '{-1,  6, -12, 8};
      CUB_EDGE_L:  coef = '{-2, -6,   0, 4};
      CUB_EDGE_R:  coef = '{ 3, -6,   0, 4};
      CUB_NEAR_L:  coef = '{-3, -6,   0, 4};
      CUB_NEAR_R:  coef = '{ 2, -6,   0, 4};
      default:     coef = '{ 0,  0,   0, 0};
    endcase
    val   = 0;
    slope = 0;
    if (pick != CUB_NONE) begin
      // Horner form. The partial sum is brought back to units of S once,
      // before the last multiply, and the slope is the exact derivative.
      h     = (coef[0] * p + coef[1] * s) * p + coef[2] * s * s;
      v     = round_div(h, s) * p + coef[3] * s * s;
      g     = (3 * coef[0] * p + 2 * coef[1] * s) * p + coef[2] * s * s;
      val   = round_div(v, 6 * s);
      slope = round_div(g, 6 * s);
      if (val < 0) val = 0;
      if (val > s) val = s;
      if (slope < -2 * s) slope = -2 * s;
      if (slope > 2 * s) slope = 2 * s;
    end
    res.value = VAL_W'(val);
    res.slope = SLOPE_W'(slope);
    return res;
  endfunction

  // Random position. Most land inside the support, some sit on or right next
  // to a knot, and the rest cover the whole field so every bit toggles.
  function automatic logic signed [POS_W-1:0] rand_position();
    int s;
    int mode;
    s    = 1 << FRAC_BITS;
    mode = $urandom_range(99);
    if (mode < 12) begin
      return POS_W'((int'($urandom_range(4)) - 2) * s + int'($urandom_range(2)) - 1);
    end else if (mode < 80) begin
      return POS_W'(int'($urandom_range(4 * s + 32)) - 2 * s - 16);
    end
    return POS_W'($urandom);
  endfunction

  // Mostly real basis kinds; now and then one of the unused codes.
  function automatic logic [KIND_W-1:0] rand_kind();
    if ($urandom_range(99) < 88) begin
      return KIND_W'($urandom_range(4, 1));
    end
    return KIND_W'($urandom_range(7));
  endfunction

  // Offers one item and returns right after the clock edge that accepts it.
  // Valid is left high so the next item can follow without a gap. An idle
  // stretch, if any, lowers it at the next falling edge.
  task automatic send_item(input logic signed [POS_W-1:0] pos,
                           input logic [KIND_W-1:0] kind);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      valid = 1'b0;
      @(negedge clk);
    end
    valid      = 1'b1;
    position   = pos;
    basis_kind = kind;
    do begin
      @(posedge clk);
    end while (!ready);
    shape_expect.push_back(eval_shape(pos, kind));
  endtask

  // Every kind at every knot from -2 to 2. These are the segment boundaries,
  // where the lower segment must win and the edges of the support must still
  // count as inside.
  task automatic test_knots();
    for (int kind = KIND_INTERIOR; kind <= KIND_ADJ_HI; kind++) begin
      for (int k = -2; k <= 2; k++) begin
        send_item(knot(k), KIND_W'(kind));
      end
    end
  endtask

  // Field extremes, positions just outside and just inside the support, and the unused kinds.
  task automatic test_out_of_support();
    send_item(POS_W'(-262144), KIND_INTERIOR);
    send_item(POS_W'(262143), KIND_BOUNDARY);
    send_item(POS_W'(knot(-2) - 1), KIND_ADJ_HI);
    send_item(POS_W'(knot(2) + 1), KIND_ADJ_LO);
    send_item(POS_W'(knot(-2) + 1), KIND_ADJ_LO);
    send_item(POS_W'(knot(2) - 1), KIND_ADJ_HI);
    send_item('0, 3'd0);
    send_item(knot(1) >>> 1, 3'd5);
    send_item(knot(-1), 3'd6);
    send_item(POS_W'(-1), 3'd7);
  endtask

  // One phase of random traffic with the given idle and stall rates.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int count);
    send_idle_pct = idle_pct;
    rx_stall_pct  = stall_pct;
    for (int i = 0; i < count; i++) begin
      send_item(rand_position(), rand_kind());
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // items back to back. The pipeline fills up, and ready must drop until the
  // receiver picks up again. No item may be lost or duplicated.
  task automatic test_full_pipeline_stall();
    send_idle_pct = 0;
    rx_stall_pct  = 0;
    fork
      begin
        rx_hold = 1'b1;
        repeat (60) @(posedge clk);
        rx_hold = 1'b0;
      end
      begin
        for (int i = 0; i < 40; i++) begin
          send_item(rand_position(), rand_kind());
        end
      end
    join
  endtask

  // The receiver decides at each falling edge whether to take a result.
  always @(negedge clk) begin
    result_ready = !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  // Each result taken is checked against the oldest outstanding expectation.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (shape_expect.size() == 0) begin
        $error("result with no item outstanding: shape_value %0d shape_slope %0d",
               shape_value, shape_slope);
        fail_count++;
      end else begin
        oldest_shape = shape_expect.pop_front();
        if (shape_value !== oldest_shape.value) begin
          $error("shape_value: expected %0d, actual %0d", oldest_shape.value,
                 shape_value);
          fail_count++;
        end
        if (shape_slope !== oldest_shape.slope) begin
          $error("shape_slope: expected %0d, actual %0d", oldest_shape.slope,
                 shape_slope);
          fail_count++;
        end
      end
    end
  end

  // Watchdog. It counts cycles in which neither side moves an item, so a
  // hung handshake ends the run instead of spinning forever.
  always @(posedge clk) begin
    if (rst || (valid && ready) || (result_valid && result_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_cubic_bspline_basis_eval_unit: FAIL");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    valid         = 1'b0;
    position      = '0;
    basis_kind    = '0;
    rx_hold       = 1'b0;
    send_idle_pct = 0;
    rx_stall_pct  = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_knots();
    test_out_of_support();
    // No idling first, then a slow sender, a slow receiver, and both a bit slow.
    test_random_traffic(0, 0, 125);
    test_random_traffic(59, 0, 125);
    test_random_traffic(0, 59, 125);
    test_random_traffic(18, 18, 125);
    test_full_pipeline_stall();

    @(negedge clk);
    valid = 1'b0;
    while (shape_expect.size() != 0) begin
      @(posedge clk);
    end
    // Wait well past the pipeline depth to catch any stray result.
    repeat (2 * NUM_STAGES + 4) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb_cubic_bspline_basis_eval_unit: PASS");
    end else begin
      $display("tb_cubic_bspline_basis_eval_unit: FAIL");
    end
    $finish;
  end

endmodule
